// ===== hw/rtl/rse_pkg.sv =====
`default_nettype none

package rse_pkg;

	localparam logic [63:0] FX_MIN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] FX_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

	// token commands
	typedef enum logic [2:0] {
		CMD_PUSH = 3'd0,
		CMD_ADD  = 3'd1,
		CMD_SUB  = 3'd2,
		CMD_MUL  = 3'd3,
		CMD_DIV  = 3'd4,
		CMD_NEG  = 3'd5
	} cmd_t;

	// error codes, first one held until the last token
	typedef enum logic [2:0] {
		ERR_OK         = 3'd0,
		ERR_DIV0       = 3'd1,
		ERR_UNDERFLOW  = 3'd2,
		ERR_OVERFLOW   = 3'd3,
		ERR_NOT_SINGLE = 3'd4
	} err_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_READ_LHS,
		S_EXEC,
		S_MDU,
		S_FINISH,
		S_RESULT
	} state_t;

	typedef enum logic {
		MDU_MUL = 1'b0,
		MDU_DIV = 1'b1
	} mdu_op_t;

	typedef struct packed {
		logic    start;
		mdu_op_t op;
	} mdu_req_t;

	// input word: one token
	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [63:0] operand_value;
		logic               is_last;
	} tok_word_t;

	// output word: expression result
	typedef struct packed {
		logic signed [63:0] result_value;
		logic [2:0]         error_code;
	} res_word_t;

	function automatic logic [63:0] fx_mag(input logic [63:0] v);
		return v[63] ? (64'd0 - v) : v;
	endfunction

	function automatic logic [63:0] fx_add(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] r;
		r = a + b;
		if (a[63] == b[63] && r[63] != a[63])
			return a[63] ? FX_MIN : FX_MAX;
		return r;
	endfunction

	function automatic logic [63:0] fx_sub(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] r;
		r = a - b;
		if (a[63] != b[63] && r[63] != a[63])
			return a[63] ? FX_MIN : FX_MAX;
		return r;
	endfunction

	function automatic logic [63:0] fx_neg(input logic [63:0] a);
		if (a == FX_MIN)
			return FX_MAX;
		return 64'd0 - a;
	endfunction

	// sign a 128-bit magnitude and clamp to the 64-bit range
	function automatic logic [63:0] fx_sat(input logic neg, input logic [127:0] q);
		if (neg) begin
			if (q[127:64] != 64'd0 || q[63:0] > FX_MIN)
				return FX_MIN;
			return 64'd0 - q[63:0];
		end
		if (q[127:64] != 64'd0 || q[63:0] > FX_MAX)
			return FX_MAX;
		return q[63:0];
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rse_ram.sv =====
`default_nettype none

module rse_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rse_mdu.sv =====
`default_nettype none

module rse_mdu
	import rse_pkg::*;
#(
	parameter int FRAC_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire mdu_req_t    req,
	input  wire logic [63:0] lhs,
	input  wire logic [63:0] rhs,
	output logic             done,
	output logic [63:0]      result
);

	localparam int MUL_STEPS = 64;
	localparam int DIV_STEPS = 128;

	logic          busy_q;
	logic          done_q;
	logic [6:0]    cnt_q;
	mdu_op_t       op_q;
	logic          neg_q;
	logic [63:0]   acc_q;
	logic [127:0]  wide_q;
	logic [63:0]   d_q;

	logic          is_mul;
	logic          sub;
	logic [64:0]   r_sh;
	logic [64:0]   a65;
	logic [64:0]   b65;
	logic [65:0]   sum66;
	logic [64:0]   mul_t;
	logic          ge;
	logic [127:0]  prod_sh;
	logic [127:0]  q;

	// shared 65-bit adder: accumulate for multiply, trial subtract for divide
	always_comb begin
		is_mul  = (op_q == MDU_MUL);
		sub     = !is_mul;
		r_sh    = {acc_q, wide_q[127]};
		a65     = is_mul ? {1'b0, acc_q} : r_sh;
		b65     = {1'b0, d_q};
		sum66   = {1'b0, a65} + {1'b0, sub ? ~b65 : b65} + {65'd0, sub};
		mul_t   = wide_q[0] ? sum66[64:0] : {1'b0, acc_q};
		ge      = sum66[65];
		prod_sh = {acc_q, wide_q[63:0]} >> FRAC_BITS;
		q       = is_mul ? prod_sh : wide_q;
	end

	assign result = fx_sat(neg_q, q);
	assign done   = done_q;

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= (req.op == MDU_MUL) ? 7'(MUL_STEPS - 1) : 7'(DIV_STEPS - 1);
		end else begin
			done_q <= busy_q && cnt_q == 7'd0;
			if (busy_q) begin
				if (cnt_q == 7'd0)
					busy_q <= 1'b0;
				else
					cnt_q <= cnt_q - 7'd1;
			end
		end
	end

	// shift-add multiply and restoring divide, one bit a cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			neg_q <= lhs[63] ^ rhs[63];
			acc_q <= '0;
			if (req.op == MDU_MUL) begin
				d_q    <= fx_mag(lhs);
				wide_q <= {64'd0, fx_mag(rhs)};
			end else begin
				d_q    <= fx_mag(rhs);
				wide_q <= {64'd0, fx_mag(lhs)} << FRAC_BITS;
			end
		end else if (busy_q) begin
			if (is_mul) begin
				acc_q  <= mul_t[64:1];
				wide_q <= {wide_q[127:64], mul_t[0], wide_q[63:1]};
			end else begin
				acc_q  <= ge ? sum66[63:0] : r_sh[63:0];
				wide_q <= {wide_q[126:0], ge};
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rpn_stack_evaluator_top.sv =====
// Postfix expression evaluator, signed fixed point with FRAC_BITS fraction bits.
// Tokens arrive as words on the tok channel (tok_valid / tok_stall); a token
// is taken when tok_valid is high and tok_stall is low. tok_stall is high
// while a token is being worked on. The token marked is_last produces one
// word on the res channel (value and error code), then the stack is cleared.
// Token time is set by the stack RAM's registered read port and the
// bit-serial multiply/divide unit: push writes in S_DECODE, negate adds
// S_EXEC, add/subtract add S_READ_LHS and S_EXEC, multiply/divide also S_MDU;
// a token with an error already held only passes S_DECODE. A last token also
// passes S_FINISH and S_RESULT before its result is loaded into the output
// register. The output register lets the next token in while a result waits;
// if res_stall holds it, a further last token waits until it is taken.
// Reset (arst_n low) empties the stack, clears the held error and drops
// res_valid. Stack contents are not cleared; only live entries are read.
`default_nettype none

module rpn_stack_evaluator_top
	import rse_pkg::*;
#(
	parameter int STACK_DEPTH = 16,
	parameter int FRAC_BITS   = 32
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      tok_valid,
	output logic           tok_stall,
	input  wire tok_word_t tok,
	output logic           res_valid,
	input  wire logic      res_stall,
	output res_word_t      res
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	state_t       state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	err_t         err_q, err_d;
	logic [2:0]   cmd_q;
	logic [63:0]  val_q;
	logic         last_q;
	logic [63:0]  rhs_q;
	logic         res_valid_q;
	res_word_t    res_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [63:0]   ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [63:0]   rd_data;

	mdu_req_t      mdu_req;
	logic          mdu_done;
	logic [63:0]   mdu_result;

	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] cnt_m2;
	logic [AW-1:0] top_addr;
	logic [AW-1:0] nxt_addr;
	err_t          final_err;
	state_t        after_op;
	logic          res_load;
	res_word_t     res_word;

	rse_ram #(
		.WIDTH (64),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	rse_mdu #(
		.FRAC_BITS (FRAC_BITS)
	) u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mdu_req),
		.lhs    (rd_data),
		.rhs    (rhs_q),
		.done   (mdu_done),
		.result (mdu_result)
	);

	assign tok_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// sequencer: next state, stack access, unit start
	always_comb begin
		cnt_m1    = count_q - CW'(1);
		cnt_m2    = count_q - CW'(2);
		top_addr  = cnt_m1[AW-1:0];
		nxt_addr  = cnt_m2[AW-1:0];
		after_op  = last_q ? S_FINISH : S_IDLE;
		if (err_q != ERR_OK)
			final_err = err_q;
		else if (count_q != CW'(1))
			final_err = ERR_NOT_SINGLE;
		else
			final_err = ERR_OK;

		state_d   = state_q;
		count_d   = count_q;
		err_d     = err_q;
		ram_we    = 1'b0;
		ram_waddr = top_addr;
		ram_wdata = val_q;
		ram_raddr = top_addr;
		mdu_req   = '{start: 1'b0, op: MDU_MUL};
		res_load  = 1'b0;
		res_word.result_value = (final_err == ERR_OK) ? rd_data : 64'd0;
		res_word.error_code   = final_err;

		case (state_q)
			S_IDLE: begin
				if (tok_valid)
					state_d = S_DECODE;
			end
			S_DECODE: begin
				state_d = after_op;
				if (err_q == ERR_OK) begin
					case (cmd_t'(cmd_q))
						CMD_PUSH: begin
							if (count_q == CW'(STACK_DEPTH)) begin
								err_d = ERR_OVERFLOW;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = count_q[AW-1:0];
								count_d   = count_q + CW'(1);
							end
						end
						CMD_NEG: begin
							if (count_q == CW'(0))
								err_d = ERR_UNDERFLOW;
							else
								state_d = S_EXEC;
						end
						CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
							if (count_q < CW'(2))
								err_d = ERR_UNDERFLOW;
							else
								state_d = S_READ_LHS;
						end
						default: ;
					endcase
				end
			end
			S_READ_LHS: begin
				ram_raddr = nxt_addr;
				state_d   = S_EXEC;
			end
			S_EXEC: begin
				state_d = after_op;
				case (cmd_t'(cmd_q))
					CMD_NEG: begin
						ram_we    = 1'b1;
						ram_waddr = top_addr;
						ram_wdata = fx_neg(rd_data);
					end
					CMD_ADD: begin
						ram_we    = 1'b1;
						ram_waddr = nxt_addr;
						ram_wdata = fx_add(rd_data, rhs_q);
						count_d   = cnt_m1;
					end
					CMD_SUB: begin
						ram_we    = 1'b1;
						ram_waddr = nxt_addr;
						ram_wdata = fx_sub(rd_data, rhs_q);
						count_d   = cnt_m1;
					end
					CMD_MUL: begin
						mdu_req = '{start: 1'b1, op: MDU_MUL};
						state_d = S_MDU;
					end
					CMD_DIV: begin
						if (rhs_q == 64'd0) begin
							err_d = ERR_DIV0;
						end else begin
							mdu_req = '{start: 1'b1, op: MDU_DIV};
							state_d = S_MDU;
						end
					end
					default: ;
				endcase
			end
			S_MDU: begin
				if (mdu_done) begin
					ram_we    = 1'b1;
					ram_waddr = nxt_addr;
					ram_wdata = mdu_result;
					count_d   = cnt_m1;
					state_d   = after_op;
				end
			end
			S_FINISH: begin
				ram_raddr = '0;
				state_d   = S_RESULT;
			end
			S_RESULT: begin
				ram_raddr = '0;
				if (!res_valid_q || !res_stall) begin
					res_load = 1'b1;
					count_d  = '0;
					err_d    = ERR_OK;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			err_q       <= ERR_OK;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			err_q   <= err_d;
			if (res_load)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	// token, right operand and result words
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && tok_valid) begin
			cmd_q  <= tok.cmd;
			val_q  <= tok.operand_value;
			last_q <= tok.is_last;
		end
		if (state_q == S_READ_LHS)
			rhs_q <= rd_data;
		if (res_load)
			res_q <= res_word;
	end

endmodule

`default_nettype wire

// ===== verif/rpn_stack_evaluator_top_test.sv =====
`timescale 1ns / 100ps

module rpn_stack_evaluator_top_test;
	import rse_pkg::*;

	localparam int STACK_DEPTH  = 16;
	localparam int FRAC_BITS    = 32;
	localparam int RANDOM_ITEMS = 525;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 300;

	// command codes the block does not decode
	localparam logic [2:0] CMD_RSVD_6 = 3'd6;
	localparam logic [2:0] CMD_RSVD_7 = 3'd7;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      tok_valid = 1'b0;
	logic      tok_stall;
	tok_word_t tok = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	res_word_t res;

	// predicted evaluator state
	logic [63:0] stack_img [STACK_DEPTH];
	int          depth_now = 0;
	err_t        sticky = ERR_OK;
	res_word_t   pending_results [$];

	int mismatches   = 0;
	int results_seen = 0;
	int tokens_sent  = 0;
	int burst_left   = 0;
	int idle_cycles  = 0;

	int stall_mode       = 0;
	int stall_phase_left = 0;
	int stall_run        = 0;

	rpn_stack_evaluator_top #(
		.STACK_DEPTH(STACK_DEPTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.tok      (tok),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// ---------------------------------------------------------------
	// fixed point arithmetic, saturating
	// ---------------------------------------------------------------

	// 65-bit signed intermediate back to 64 bits
	function automatic logic [63:0] clamp_wide(input logic [64:0] s);
		if (s[64] != s[63])
			return s[64] ? FX_MIN : FX_MAX;
		return s[63:0];
	endfunction

	function automatic logic [127:0] magnitude_of(input logic [63:0] v);
		logic [63:0] m;
		m = v[63] ? (64'd0 - v) : v;
		return {64'd0, m};
	endfunction

	// apply sign to an unsigned magnitude and clamp
	function automatic logic [63:0] clamp_signed(input logic neg, input logic [127:0] q);
		if (neg) begin
			if (q > 128'h8000_0000_0000_0000)
				return FX_MIN;
			return 64'd0 - q[63:0];
		end
		if (q > {64'd0, FX_MAX})
			return FX_MAX;
		return q[63:0];
	endfunction

	function automatic logic [63:0] negate_value(input logic [63:0] a);
		return clamp_wide(65'd0 - {a[63], a});
	endfunction

	function automatic logic [63:0] combine(input logic [2:0] op, input logic [63:0] lhs,
			input logic [63:0] rhs);
		logic [127:0] q;
		logic         neg;
		neg = lhs[63] ^ rhs[63];
		case (op)
			CMD_ADD: return clamp_wide({lhs[63], lhs} + {rhs[63], rhs});
			CMD_SUB: return clamp_wide({lhs[63], lhs} - {rhs[63], rhs});
			CMD_MUL: begin
				q = (magnitude_of(lhs) * magnitude_of(rhs)) >> FRAC_BITS;
				return clamp_signed(neg, q);
			end
			default: begin
				q = (magnitude_of(lhs) << FRAC_BITS) / magnitude_of(rhs);
				return clamp_signed(neg, q);
			end
		endcase
	endfunction

	// one token through the predicted evaluator; queues a result on the last token
	task automatic evaluate_token(input tok_word_t w);
		logic [63:0] lhs;
		logic [63:0] rhs;
		res_word_t   r;
		if (sticky == ERR_OK && w.cmd <= CMD_NEG) begin
			case (w.cmd)
				CMD_PUSH: begin
					if (depth_now >= STACK_DEPTH) begin
						sticky = ERR_OVERFLOW;
					end else begin
						stack_img[depth_now] = w.operand_value;
						depth_now++;
					end
				end
				CMD_NEG: begin
					if (depth_now < 1)
						sticky = ERR_UNDERFLOW;
					else
						stack_img[depth_now - 1] = negate_value(stack_img[depth_now - 1]);
				end
				default: begin
					if (depth_now < 2) begin
						sticky = ERR_UNDERFLOW;
					end else begin
						rhs = stack_img[depth_now - 1];
						lhs = stack_img[depth_now - 2];
						if (w.cmd == CMD_DIV && rhs == 64'd0) begin
							sticky = ERR_DIV0;
						end else begin
							depth_now--;
							stack_img[depth_now - 1] = combine(w.cmd, lhs, rhs);
						end
					end
				end
			endcase
		end
		if (w.is_last) begin
			if (sticky == ERR_OK && depth_now != 1)
				sticky = ERR_NOT_SINGLE;
			r.result_value = (sticky == ERR_OK) ? stack_img[0] : 64'd0;
			r.error_code   = sticky;
			pending_results.push_back(r);
			depth_now = 0;
			sticky    = ERR_OK;
		end
	endtask

	// ---------------------------------------------------------------
	// token sender: bursts with random gaps
	// ---------------------------------------------------------------
	task automatic send_token(input logic [2:0] cmd, input logic [63:0] value,
			input logic last);
		tok_word_t w;
		w.cmd           = cmd;
		w.operand_value = value;
		w.is_last       = last;
		tok       <= w;
		tok_valid <= 1'b1;
		do
			@(posedge clk);
		while (tok_stall);
		evaluate_token(w);
		tokens_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			tok_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom_range(10, 60);
		end
	endtask

	// ---------------------------------------------------------------
	// result receiver: stall pattern in phases
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (stall_phase_left == 0) begin
			stall_mode       <= $urandom_range(0, 2);
			stall_phase_left <= $urandom_range(20, 200);
		end else begin
			stall_phase_left <= stall_phase_left - 1;
		end
		case (stall_mode)
			0: res_stall <= 1'b0;
			1: res_stall <= ($urandom_range(0, 2) == 0);
			default: begin
				if (stall_run == 0) begin
					res_stall <= !res_stall;
					stall_run <= $urandom_range(1, 20);
				end else begin
					stall_run <= stall_run - 1;
				end
			end
		endcase
	end

	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		$display("mismatch on result %0d: %s expected %h got %h", results_seen, what, want, got);
		mismatches++;
	endtask

	// compare each result word with the oldest prediction
	always @(posedge clk) begin
		res_word_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word", 64'd0, res.result_value);
			end else begin
				want = pending_results.pop_front();
				if (res.result_value !== want.result_value)
					report_mismatch("result_value", want.result_value, res.result_value);
				if (res.error_code !== want.error_code)
					report_mismatch("error_code", 64'(want.error_code), 64'(res.error_code));
			end
			results_seen++;
		end
	end

	// watchdog: cycles with no word moving on either channel
	always @(posedge clk) begin
		if ((tok_valid && !tok_stall) || (res_valid && !res_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------
	function automatic logic [63:0] q_int(input int n);
		return 64'(longint'(n) <<< FRAC_BITS);
	endfunction

	function automatic logic [63:0] random_operand();
		case ($urandom_range(0, 11))
			0: return 64'd0;
			1: return FX_MIN;
			2: return FX_MAX;
			3: return 64'd1;
			4: return {64{1'b1}};
			5, 6: return {$urandom, $urandom};
			default: return {32'(int'($urandom_range(0, 200)) - 100), 32'($urandom)};
		endcase
	endfunction

	// arithmetic with exact and saturating results
	task automatic test_arithmetic();
		send_token(CMD_PUSH, 64'h2_8000_0000, 1'b0);
		send_token(CMD_PUSH, q_int(-3), 1'b0);
		send_token(CMD_MUL, 64'd0, 1'b1);
		send_token(CMD_PUSH, q_int(-7), 1'b0);
		send_token(CMD_PUSH, q_int(2), 1'b0);
		send_token(CMD_DIV, {64{1'b1}}, 1'b1);
		send_token(CMD_PUSH, FX_MAX, 1'b0);
		send_token(CMD_PUSH, FX_MAX, 1'b0);
		send_token(CMD_ADD, 64'd0, 1'b1);
		send_token(CMD_PUSH, FX_MIN, 1'b0);
		send_token(CMD_PUSH, 64'd1, 1'b0);
		send_token(CMD_SUB, 64'd0, 1'b1);
		send_token(CMD_PUSH, FX_MIN, 1'b0);
		send_token(CMD_NEG, 64'd0, 1'b1);
	endtask

	// error paths, reserved commands, tokens after an error
	task automatic test_error_cases();
		send_token(CMD_PUSH, q_int(1), 1'b0);
		send_token(CMD_PUSH, 64'd0, 1'b0);
		send_token(CMD_DIV, 64'd0, 1'b0);
		send_token(CMD_ADD, 64'd0, 1'b1);
		send_token(CMD_NEG, 64'd0, 1'b1);
		send_token(CMD_PUSH, q_int(5), 1'b0);
		send_token(CMD_ADD, 64'd0, 1'b1);
		send_token(CMD_PUSH, 64'h1234_5678_9ABC_DEF0, 1'b0);
		send_token(CMD_RSVD_6, FX_MAX, 1'b0);
		send_token(CMD_RSVD_7, FX_MIN, 1'b1);
		send_token(CMD_PUSH, q_int(3), 1'b0);
		send_token(CMD_PUSH, q_int(4), 1'b1);
	endtask

	// one random expression: mostly well formed, some broken or noise
	task automatic random_expression();
		tok_word_t seq [$];
		tok_word_t w;
		int        depth;
		int        ops;
		int        mode;
		int        pick;
		depth = 0;
		mode  = $urandom_range(0, 29);
		if (mode == 0) begin
			// run the stack past its top
			repeat (STACK_DEPTH + $urandom_range(1, 2)) begin
				w = '{CMD_PUSH, random_operand(), 1'b0};
				seq.push_back(w);
			end
		end else if (mode <= 3) begin
			repeat ($urandom_range(1, 6)) begin
				w = '{3'($urandom_range(0, 7)), {$urandom, $urandom}, 1'b0};
				seq.push_back(w);
			end
		end else begin
			ops = $urandom_range(0, 9);
			while (ops > 0 || depth != 1) begin
				if (depth == 0 || (depth == 1 && (ops == 0 || $urandom_range(0, 3) != 0))
						|| (depth < 14 && ops > depth && $urandom_range(0, 2) == 0)) begin
					w = '{CMD_PUSH, random_operand(), 1'b0};
					depth++;
				end else begin
					pick = (depth == 1) ? 0 : $urandom_range(0, 10);
					w.operand_value = {$urandom, $urandom};
					w.is_last       = 1'b0;
					if (pick == 0) begin
						w.cmd = CMD_NEG;
					end else begin
						w.cmd = (pick <= 3) ? CMD_ADD : (pick <= 6) ? CMD_SUB :
							(pick <= 8) ? CMD_MUL : CMD_DIV;
						depth--;
					end
					if (ops > 0)
						ops--;
				end
				seq.push_back(w);
			end
			// occasionally leave the expression one token short or one value over
			pick = $urandom_range(0, 15);
			if (pick == 0 && seq.size() > 1) begin
				void'(seq.pop_back());
			end else if (pick == 1) begin
				w = '{CMD_PUSH, random_operand(), 1'b0};
				seq.push_back(w);
			end
		end
		seq[seq.size() - 1].is_last = 1'b1;
		foreach (seq[i])
			send_token(seq[i].cmd, seq[i].operand_value, seq[i].is_last);
	endtask

	task automatic test_random_expressions();
		int start;
		start = tokens_sent;
		while (tokens_sent - start < RANDOM_ITEMS)
			random_expression();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_arithmetic();
		test_error_cases();
		test_random_expressions();
		tok_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
